>>> rtl/csd_pkg.sv
// Shared types and constants of the charset byte stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package csd_pkg;

  localparam int PADDR_W  = 1;
  localparam int PDATA_W  = 32;
  localparam int MODE_W   = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [PADDR_W-1:0] ADDR_ENCODING_MODE = '0;

  localparam logic [MODE_W-1:0] MODE_LATIN1 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UTF8   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UCS2BE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ASCII  = 3'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_CONT = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  typedef enum logic [2:0] {
    K_PASS,
    K_UNSUP,
    K_UCS2,
    K_U8_ASCII,
    K_U8_LEAD2,
    K_U8_LEAD3,
    K_U8_CONT,
    K_U8_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

endpackage
`default_nettype wire

>>> rtl/csd_if.sv
// Stream interfaces for the byte input and the character result channels.
`timescale 1ns / 1ps
`default_nettype none
interface csd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface csd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic [1:0]  bytes_used;
  logic [1:0]  status;

  modport source (output valid, char_code, bytes_used, status, input ready);
  modport sink (input valid, char_code, bytes_used, status, output ready);
endinterface
`default_nettype wire

>>> rtl/charset_byte_stream_decoder_top.sv
// Top level of the charset byte stream decoder.
// Usage:
//   in_if carries one raw byte per item (data_byte) plus last_byte, which marks
//   the final byte of a buffer. out_if carries one decoded 16-bit code unit per
//   item with bytes_used and status (0 ok, 1 bad lead or mode, 2 bad
//   continuation, 3 truncated). Bytes that only extend a partial character
//   give no result item.
//   The APB port holds encoding_mode at address 0; a write also drops any
//   partial character. Write it only while the block is idle.
//   Throughput: one byte per cycle while the queue is not full. A result
//   passes through the queue, written when its final byte is accepted, and
//   then through the output register before it is valid.
//   A two-item queue separates byte classification from character assembly;
//   in_if.ready drops only while that queue is full.
//   When out_if.ready is low the result register holds and the queue fills,
//   then in_if.ready falls.
//   Synchronous reset clears the queue, the partial character, the output
//   valid flag and sets encoding_mode to latin1.
`timescale 1ns / 1ps
`default_nettype none
module charset_byte_stream_decoder_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  csd_in_if.sink                            in_if,
  csd_out_if.source                         out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [csd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [csd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [csd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import csd_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              mode_wr;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_not_empty;
  tok_t              push_tok;
  tok_t              head_tok;

  assign pready  = 1'b1;
  assign mode_wr = psel && penable && pwrite && pready && (paddr == ADDR_ENCODING_MODE);
  assign prdata  = (paddr == ADDR_ENCODING_MODE) ? {{(PDATA_W-MODE_W){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LATIN1;
    end else if (mode_wr) begin
      mode_r <= pwdata[MODE_W-1:0];
    end
  end

  csd_front u_front (
    .in_if  (in_if),
    .mode   (mode_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_tok  (push_tok)
  );

  csd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (push_tok),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  csd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (mode_wr),
    .q_not_empty (q_not_empty),
    .q_tok       (head_tok),
    .q_pop       (q_pop),
    .out_if      (out_if)
  );

endmodule
`default_nettype wire

>>> rtl/csd_front.sv
// Front stage: accept bytes and classify them by encoding mode and bit pattern.
`timescale 1ns / 1ps
`default_nettype none
module csd_front (
  csd_in_if.sink                      in_if,
  input  wire logic [csd_pkg::MODE_W-1:0] mode,
  input  wire logic                   q_full,
  output logic                        q_push,
  output csd_pkg::tok_t               q_tok
);
  import csd_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (mode) inside
      MODE_LATIN1, MODE_ASCII: kind = K_PASS;
      MODE_UCS2BE:             kind = K_UCS2;
      MODE_UTF8: begin
        if (!in_if.data_byte[7]) begin
          kind = K_U8_ASCII;
        end else if (in_if.data_byte[7:6] == 2'b10) begin
          kind = K_U8_CONT;
        end else if (in_if.data_byte[7:5] == 3'b110) begin
          kind = K_U8_LEAD2;
        end else if (in_if.data_byte[7:4] == 4'b1110) begin
          kind = K_U8_LEAD3;
        end else begin
          kind = K_U8_BAD;
        end
      end
      default: kind = K_UNSUP;
    endcase
  end

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;
  assign q_tok.kind  = kind;
  assign q_tok.data  = in_if.data_byte;
  assign q_tok.last  = in_if.last_byte;

endmodule
`default_nettype wire

>>> rtl/csd_queue.sv
// Short queue of classified items between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none
module csd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire csd_pkg::tok_t push_tok,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output csd_pkg::tok_t      head_tok
);
  import csd_pkg::*;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_tok  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

>>> rtl/csd_back.sv
// Back stage: assemble characters from classified items and drive the result register.
`timescale 1ns / 1ps
`default_nettype none
module csd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic          q_not_empty,
  input  wire csd_pkg::tok_t q_tok,
  output logic               q_pop,
  csd_out_if.source          out_if
);
  import csd_pkg::*;

  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [15:0] part_r, part_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] code_r;
  logic [1:0]  used_r;
  logic [1:0]  st_r;

  logic        res_v;
  logic [15:0] res_code;
  logic [1:0]  res_used;
  logic [1:0]  res_st;
  logic [15:0] shifted;

  assign q_pop   = q_not_empty && (!out_valid_r || out_if.ready);
  assign shifted = {part_r[9:0], q_tok.data[5:0]};

  always_comb begin
    res_v    = 1'b0;
    res_code = '0;
    res_used = '0;
    res_st   = ST_OK;
    pend_nxt = pend_r;
    seen_nxt = seen_r;
    part_nxt = part_r;
    case (q_tok.kind) inside
      K_PASS: begin
        res_v    = 1'b1;
        res_code = {8'h00, q_tok.data};
        res_used = 2'd1;
      end
      K_UCS2: begin
        if (pend_r != '0) begin
          res_v    = 1'b1;
          res_code = {part_r[7:0], q_tok.data};
          res_used = 2'd2;
        end else if (q_tok.last) begin
          res_v  = 1'b1;
          res_st = ST_TRUNC;
        end else begin
          part_nxt = {8'h00, q_tok.data};
          pend_nxt = 2'd1;
          seen_nxt = 2'd1;
        end
      end
      K_U8_ASCII, K_U8_LEAD2, K_U8_LEAD3, K_U8_CONT, K_U8_BAD: begin
        if (pend_r == '0) begin
          if (q_tok.kind == K_U8_ASCII) begin
            res_v    = 1'b1;
            res_code = {8'h00, q_tok.data};
            res_used = 2'd1;
          end else if (q_tok.kind == K_U8_LEAD2 || q_tok.kind == K_U8_LEAD3) begin
            if (q_tok.last) begin
              res_v  = 1'b1;
              res_st = ST_TRUNC;
            end else if (q_tok.kind == K_U8_LEAD2) begin
              part_nxt = {8'h00, q_tok.data & LEAD2_MASK};
              pend_nxt = 2'd1;
              seen_nxt = 2'd1;
            end else begin
              part_nxt = {8'h00, q_tok.data & LEAD3_MASK};
              pend_nxt = 2'd2;
              seen_nxt = 2'd1;
            end
          end else begin
            res_v  = 1'b1;
            res_st = ST_BAD_LEAD;
          end
        end else if (pend_r > 2'd1 && q_tok.last) begin
          res_v  = 1'b1;
          res_st = ST_TRUNC;
        end else if (q_tok.kind != K_U8_CONT) begin
          res_v  = 1'b1;
          res_st = ST_BAD_CONT;
        end else if (pend_r == 2'd1) begin
          res_v    = 1'b1;
          res_code = shifted;
          res_used = seen_r + 2'd1;
        end else begin
          part_nxt = shifted;
          pend_nxt = pend_r - 2'd1;
          seen_nxt = seen_r + 2'd1;
        end
      end
      default: begin
        res_v  = 1'b1;
        res_st = ST_BAD_LEAD;
      end
    endcase
    if (res_v) begin
      pend_nxt = '0;
      seen_nxt = '0;
      part_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop && res_v) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      seen_r      <= '0;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (clear) begin
        pend_r <= '0;
        seen_r <= '0;
        part_r <= '0;
      end else if (q_pop) begin
        pend_r <= pend_nxt;
        seen_r <= seen_nxt;
        part_r <= part_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_v) begin
      code_r <= res_code;
      used_r <= res_used;
      st_r   <= res_st;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.char_code  = code_r;
  assign out_if.bytes_used = used_r;
  assign out_if.status     = st_r;

endmodule
`default_nettype wire

>>> rtl/csd_checker.sv
// Port-level assertions for the charset byte stream decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module csd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] char_code,
  input wire logic [1:0]  bytes_used,
  input wire logic [1:0]  status
);
  import csd_pkg::*;

  a_used_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((status == ST_OK) == (bytes_used != 2'd0)))
    else $error("bytes_used disagrees with status");

  a_error_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |-> (char_code == 16'h0000))
    else $error("error item carries a nonzero code");

  a_single_byte_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ST_OK && bytes_used == 2'd1) |-> (char_code[15:8] == 8'h00))
    else $error("one-byte character wider than a byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(char_code) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind charset_byte_stream_decoder_top csd_checker u_csd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .char_code  (out_if.char_code),
  .bytes_used (out_if.bytes_used),
  .status     (out_if.status)
);
`default_nettype wire

>>> tb/charset_byte_stream_decoder_top_tb.sv
// Self-checking testbench for the charset byte stream decoder top level.
`timescale 1ns / 1ps
module charset_byte_stream_decoder_top_tb;
  import csd_pkg::*;

  localparam int          RANDOM_ITEMS  = 1250;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [2:0]  MODE_UNSUP_LO = 3'd4;
  localparam logic [2:0]  MODE_UNSUP_HI = 3'd7;

  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  used;
    logic [1:0]  status;
  } char_result_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  csd_in_if  in_bus ();
  csd_out_if out_bus ();

  charset_byte_stream_decoder_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  char_result_t char_q[$];
  logic [2:0]   cur_mode;
  logic [1:0]   seq_pending;
  logic [1:0]   seq_seen;
  logic [15:0]  seq_code;

  int errors;
  int bytes_sent;
  int results_checked;
  int mode_writes;
  int stall_cycles;
  int rx_hold;
  int burst_left;
  bit tx_gaps_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  function automatic void clear_sequence();
    seq_pending = '0;
    seq_seen    = '0;
    seq_code    = '0;
  endfunction

  function automatic void push_char(input logic [15:0] c, input logic [1:0] u,
                                    input logic [1:0] s);
    char_q.push_back('{code: c, used: u, status: s});
    clear_sequence();
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic l);
    case (cur_mode) inside
      MODE_LATIN1, MODE_ASCII: push_char({8'h00, b}, 2'd1, ST_OK);
      MODE_UTF8: begin
        if (seq_pending == 2'd0) begin
          if (b[7] == 1'b0) begin
            push_char({8'h00, b}, 2'd1, ST_OK);
          end else if (b[7:5] == 3'b110) begin
            if (l) begin
              push_char('0, 2'd0, ST_TRUNC);
            end else begin
              seq_code    = {8'h00, b & LEAD2_MASK};
              seq_pending = 2'd1;
              seq_seen    = 2'd1;
            end
          end else if (b[7:4] == 4'b1110) begin
            if (l) begin
              push_char('0, 2'd0, ST_TRUNC);
            end else begin
              seq_code    = {8'h00, b & LEAD3_MASK};
              seq_pending = 2'd2;
              seq_seen    = 2'd1;
            end
          end else begin
            push_char('0, 2'd0, ST_BAD_LEAD);
          end
        end else if (seq_pending > 2'd1 && l) begin
          push_char('0, 2'd0, ST_TRUNC);
        end else if (b[7:6] != 2'b10) begin
          push_char('0, 2'd0, ST_BAD_CONT);
        end else begin
          seq_code    = {seq_code[9:0], b[5:0]};
          seq_pending = seq_pending - 2'd1;
          if (seq_pending == 2'd0) push_char(seq_code, seq_seen + 2'd1, ST_OK);
          else seq_seen = seq_seen + 2'd1;
        end
      end
      MODE_UCS2BE: begin
        if (seq_pending == 2'd0) begin
          if (l) begin
            push_char('0, 2'd0, ST_TRUNC);
          end else begin
            seq_code    = {8'h00, b};
            seq_pending = 2'd1;
            seq_seen    = 2'd1;
          end
        end else begin
          push_char({seq_code[7:0], b}, 2'd2, ST_OK);
        end
      end
      default: push_char('0, 2'd0, ST_BAD_LEAD);
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    char_result_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (char_q.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_bus.char_code), 0);
        end else begin
          want = char_q.pop_front();
          if (out_bus.char_code !== want.code)
            report_mismatch("char_code", int'(out_bus.char_code), int'(want.code));
          if (out_bus.bytes_used !== want.used)
            report_mismatch("bytes_used", int'(out_bus.bytes_used), int'(want.used));
          if (out_bus.status !== want.status)
            report_mismatch("status", int'(out_bus.status), int'(want.status));
          results_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) decode_byte(in_bus.data_byte, in_bus.last_byte);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (psel && penable && pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", stall_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : rx_drive
    int         style_left;
    int         rx_style;
    int         phase;
    logic [7:0] pattern;
    out_bus.ready = 1'b0;
    style_left    = 0;
    rx_style      = 0;
    phase         = 0;
    pattern       = 8'hFF;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        rx_style   = $urandom_range(0, 3);
        style_left = $urandom_range(32, 256);
        pattern    = 8'($urandom);
        pattern[0] = 1'b1;
      end
      style_left--;
      phase++;
      if (rx_hold > 0) begin
        rx_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_style)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          2: out_bus.ready <= pattern[phase[2:0]];
          default: out_bus.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    if (tx_gaps_on && burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= l;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (char_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] m);
    logic [PDATA_W-1:0] word;
    word = $urandom;
    word[MODE_W-1:0] = m;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENCODING_MODE;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_mode = m;
    clear_sequence();
    mode_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_check();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ENCODING_MODE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[MODE_W-1:0] !== cur_mode)
      report_mismatch("encoding_mode readback", int'(prdata[MODE_W-1:0]), int'(cur_mode));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_utf8_char();
    int         k;
    logic [7:0] r1;
    logic [7:0] r2;
    logic [7:0] r3;
    k  = $urandom_range(0, 19);
    r1 = 8'($urandom);
    r2 = 8'($urandom);
    r3 = 8'($urandom);
    if (k < 5) begin
      send_byte({1'b0, r1[6:0]}, $urandom_range(0, 9) == 0);
    end else if (k < 10) begin
      send_byte({3'b110, r1[4:0]}, 1'b0);
      send_byte({2'b10, r2[5:0]}, $urandom_range(0, 9) == 0);
    end else if (k < 15) begin
      send_byte({4'b1110, r1[3:0]}, 1'b0);
      send_byte({2'b10, r2[5:0]}, 1'b0);
      send_byte({2'b10, r3[5:0]}, $urandom_range(0, 9) == 0);
    end else if (k < 17) begin
      send_byte(r1, $urandom_range(0, 3) == 0);
    end else if (k == 17) begin
      send_byte(r1[7] ? {3'b110, r1[4:0]} : {4'b1110, r1[3:0]}, 1'b1);
    end else if (k == 18) begin
      send_byte(r1[7] ? {3'b110, r1[4:0]} : {4'b1110, r1[3:0]}, 1'b0);
      send_byte({(r2[7:6] == 2'b10) ? 2'b00 : r2[7:6], r2[5:0]}, $urandom_range(0, 3) == 0);
    end else begin
      send_byte({4'b1110, r1[3:0]}, 1'b0);
      send_byte(r2, 1'($urandom_range(0, 1)));
      if (r3[0]) send_byte(r3, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_passthrough();
    cfg_check();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
    cfg_write(MODE_ASCII);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_utf8_forms();
    cfg_write(MODE_UTF8);
    cfg_check();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hC2, 1'b1);
    wait_drained();
  endtask

  task automatic test_ucs2_pairs();
    cfg_write(MODE_UCS2BE);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAB, 1'b0);
    wait_drained();
    cfg_write(MODE_UCS2BE);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    wait_drained();
  endtask

  task automatic test_unsupported_modes();
    cfg_write(MODE_UNSUP_LO);
    send_byte(8'h41, 1'b0);
    wait_drained();
    cfg_write(MODE_UNSUP_HI);
    cfg_check();
    send_byte(8'hC2, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    cfg_write(MODE_LATIN1);
    tx_gaps_on = 1'b0;
    rx_hold    = HOLD_CYCLES;
    repeat (40) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int         phase;
    int         start_all;
    int         start_chunk;
    int         chunk;
    logic [2:0] m;
    phase     = 0;
    start_all = bytes_sent;
    while (bytes_sent - start_all < RANDOM_ITEMS) begin
      case (phase)
        0: m = MODE_LATIN1;
        1: m = MODE_UNSUP_HI;
        2: m = MODE_UCS2BE;
        3: m = MODE_ASCII;
        4: m = MODE_UNSUP_LO;
        default: m = $urandom_range(0, 1) ? MODE_UTF8 : 3'($urandom_range(0, 7));
      endcase
      cfg_write(m);
      cfg_check();
      chunk       = $urandom_range(20, 80);
      start_chunk = bytes_sent;
      while (bytes_sent - start_chunk < chunk) begin
        if (m == MODE_UTF8) send_utf8_char();
        else send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
      wait_drained();
      phase++;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    errors           = 0;
    bytes_sent       = 0;
    results_checked  = 0;
    mode_writes      = 0;
    stall_cycles     = 0;
    rx_hold          = 0;
    burst_left       = 0;
    tx_gaps_on       = 1'b1;
    cur_mode         = MODE_LATIN1;
    clear_sequence();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_utf8_forms();
    test_ucs2_pairs();
    test_unsupported_modes();
    test_backpressure();
    test_random_streams();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d bytes over %0d mode writes, every encoding and invalid modes,",
             bytes_sent, mode_writes);
    $display("with output stalls and a long hold-off; %0d results checked, %0d mismatches",
             results_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
